// ===== hw/rtl/raster_to_column_page_converter_defines.svh =====
// assertion macros used by the checker file r2c_chk
`ifndef RASTER_TO_COLUMN_PAGE_CONVERTER_DEFINES_SVH
`define RASTER_TO_COLUMN_PAGE_CONVERTER_DEFINES_SVH

// concurrent assertion on clk_i, quiet while rst_ni is low
`define R2C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next
`define R2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  `R2C_ASSERT(lbl, (ante) |=> (cons), msg)

// condition must never hold
`define R2C_NEVER(lbl, cond, msg) \
  `R2C_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/r2c_pkg.sv =====
// ----------------------------------------------------------------------------
// r2c_pkg
// Types and constants shared by the raster to column page converter.
// ----------------------------------------------------------------------------
package r2c_pkg;

  // configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  // register index, taken from paddr[2]
  localparam logic        CFG_IDX_INVERT = 1'b0;

  // rows in one page
  localparam int unsigned PageRows = 8;

  // controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_SHOW
  } r2c_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_en;
    logic rd_en;
    logic grp_clr;
    logic grp_inc;
    logic out_valid;
  } r2c_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic out_ready;
    logic page_done;
    logic last_group;
  } r2c_stat_t;

endpackage

// ===== hw/rtl/r2c_if.sv =====
// ----------------------------------------------------------------------------
// r2c_if
// Stream interfaces for pixel bytes in and column groups out.
// ----------------------------------------------------------------------------
interface r2c_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       frame_start;

  modport source (output valid, output pixel_byte, output frame_start, input ready);
  modport sink   (input valid, input pixel_byte, input frame_start, output ready);
endinterface

interface r2c_col_if;
  logic        valid;
  logic        ready;
  logic [63:0] column_bytes;
  logic [2:0]  page_index;
  logic [4:0]  column_group;
  logic        last_of_page;
  logic        last_of_frame;

  modport source (output valid, output column_bytes, output page_index,
                  output column_group, output last_of_page, output last_of_frame,
                  input ready);
  modport sink   (input valid, input column_bytes, input page_index,
                  input column_group, input last_of_page, input last_of_frame,
                  output ready);
endinterface

// ===== hw/rtl/r2c_regs.sv =====
// ----------------------------------------------------------------------------
// r2c_regs
// APB-style register file holding the output inversion control.
// ----------------------------------------------------------------------------
module r2c_regs import r2c_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output logic                invert_o
);

  logic invert_q, invert_d;
  logic wr_en;

  // write strobe on the access phase
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == CFG_IDX_INVERT);

  always_comb begin
    invert_d = invert_q;
    if (wr_en) begin
      invert_d = pwdata[0];
    end
  end

  // inversion defaults to on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b1;
    end else begin
      invert_q <= invert_d;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_IDX_INVERT) begin
      prdata = {{(CfgDataW-1){1'b0}}, invert_q};
    end
  end

  assign invert_o = invert_q;

endmodule

// ===== hw/rtl/r2c_ctrl.sv =====
// ----------------------------------------------------------------------------
// r2c_ctrl
// Sequencer: loads rows, then reads and presents one column group at a time.
// ----------------------------------------------------------------------------
module r2c_ctrl import r2c_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  r2c_stat_t stat_i,
  output r2c_cmd_t  cmd_o
);

  r2c_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (stat_i.in_valid && stat_i.page_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (stat_i.out_ready) begin
          state_d = stat_i.last_group ? ST_LOAD : ST_READ;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.load_en = 1'b1;
        cmd_o.grp_clr = 1'b1;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_SHOW: begin
        cmd_o.out_valid = 1'b1;
        cmd_o.grp_inc   = stat_i.out_ready && !stat_i.last_group;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/r2c_dpath.sv =====
// ----------------------------------------------------------------------------
// r2c_dpath
// Row and byte counters, page memory and the column transpose.
// ----------------------------------------------------------------------------
module r2c_dpath import r2c_pkg::*; #(
  parameter int IMAGE_WIDTH  = 160,
  parameter int IMAGE_HEIGHT = 43
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  r2c_cmd_t    cmd_i,
  output r2c_stat_t   stat_o,
  input  logic        invert_i,
  input  logic        in_valid_i,
  input  logic [7:0]  pixel_byte_i,
  input  logic        frame_start_i,
  input  logic        out_ready_i,
  output logic [63:0] column_bytes_o,
  output logic [2:0]  page_index_o,
  output logic [4:0]  column_group_o,
  output logic        last_of_page_o,
  output logic        last_of_frame_o
);

  localparam int RowBytes = IMAGE_WIDTH / 8;
  localparam int BW       = (RowBytes > 1) ? $clog2(RowBytes) : 1;
  localparam int RW       = ($clog2(IMAGE_HEIGHT) > 6) ? $clog2(IMAGE_HEIGHT) : 6;
  localparam int GW       = (BW > 5) ? BW : 5;

  logic [RW-1:0] row_q, row_d, rc;
  logic [BW-1:0] byte_q, byte_d, bc;
  logic [BW-1:0] grp_q, grp_d;
  logic [GW-1:0] grp_ext;
  logic          accept, row_end, frame_end, page_end, last_group;

  // page meta, latched when a page completes
  logic [2:0]    page_q;
  logic [3:0]    rows_q;
  logic          fend_q;

  // one word per column byte, one byte lane per page row
  logic [63:0]   page_mem [RowBytes];
  logic [63:0]   rd_q;

  logic [7:0]    src [PageRows];
  logic [63:0]   col;

  // position of the incoming byte
  assign accept    = in_valid_i && cmd_i.load_en;
  assign rc        = frame_start_i ? '0 : row_q;
  assign bc        = frame_start_i ? '0 : byte_q;
  assign row_end   = (bc == BW'(RowBytes - 1));
  assign frame_end = (rc == RW'(IMAGE_HEIGHT - 1));
  assign page_end  = row_end && ((rc[2:0] == 3'd7) || frame_end);

  // counter update, a frame start clears the row count even in mid row
  always_comb begin
    row_d  = row_q;
    byte_d = byte_q;
    if (accept) begin
      if (row_end) begin
        byte_d = '0;
        row_d  = frame_end ? '0 : rc + RW'(1);
      end else begin
        byte_d = bc + BW'(1);
        row_d  = rc;
      end
    end
  end

  // column group walk
  assign last_group = (grp_q == BW'(RowBytes - 1));
  always_comb begin
    grp_d = grp_q;
    if (cmd_i.grp_clr) begin
      grp_d = '0;
    end else if (cmd_i.grp_inc) begin
      grp_d = grp_q + BW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      byte_q <= '0;
      grp_q  <= '0;
    end else begin
      row_q  <= row_d;
      byte_q <= byte_d;
      grp_q  <= grp_d;
    end
  end

  // page meta
  always_ff @(posedge clk_i) begin
    if (accept && page_end) begin
      page_q <= rc[5:3];
      rows_q <= {1'b0, rc[2:0]} + 4'd1;
      fend_q <= frame_end;
    end
  end

  // page memory, byte-lane write and registered read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_mem[bc][{rc[2:0], 3'b000} +: 8] <= pixel_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= page_mem[grp_q];
    end
  end

  // mask rows beyond the page and transpose
  always_comb begin
    for (int j = 0; j < PageRows; j++) begin
      src[j] = (4'(j) < rows_q) ? rd_q[8*j +: 8] : 8'h00;
    end
    for (int k = 0; k < 8; k++) begin
      for (int j = 0; j < PageRows; j++) begin
        col[8*k + j] = src[j][7-k];
      end
    end
  end

  // result payload
  assign grp_ext         = GW'(grp_q);
  assign column_bytes_o  = col ^ {64{invert_i}};
  assign page_index_o    = page_q;
  assign column_group_o  = grp_ext[4:0];
  assign last_of_page_o  = last_group;
  assign last_of_frame_o = last_group && fend_q;

  // status
  assign stat_o.in_valid   = in_valid_i;
  assign stat_o.out_ready  = out_ready_i;
  assign stat_o.page_done  = page_end;
  assign stat_o.last_group = last_group;

endmodule

// ===== hw/rtl/raster_to_column_page_converter.sv =====
// ----------------------------------------------------------------------------
// raster_to_column_page_converter
// Buffers up to eight raster rows and emits them as column bytes, eight per group.
// ----------------------------------------------------------------------------
//   channel  direction  handshake      payload
//   pix_i    in         valid/ready    pixel_byte, frame_start
//   col_o    out        valid/ready    column_bytes, page_index, column_group,
//                                      last_of_page, last_of_frame
//   apb      in         psel/penable   invert_output at byte address 0
//
// A pixel byte is taken every cycle while rows load and pix_i.valid is high. The
// byte that completes a page starts emission of IMAGE_WIDTH/8 groups, each a
// memory read state followed by an output state held until col_o is ready; no
// further byte is taken until the last group of the page has gone out.
// A stall on col_o holds the group and extends emission.
// Reset is asynchronous, active low; the page memory needs no clearing pass.
// ----------------------------------------------------------------------------
module raster_to_column_page_converter import r2c_pkg::*; #(
  parameter int IMAGE_WIDTH  = 160,
  parameter int IMAGE_HEIGHT = 43
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  r2c_pix_if.sink             pix_i,
  r2c_col_if.source           col_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  r2c_cmd_t  cmd;
  r2c_stat_t stat;
  logic      invert;

  // configuration registers
  r2c_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .invert_o (invert)
  );

  // sequencer
  r2c_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // counters, page memory, transpose
  r2c_dpath #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .invert_i        (invert),
    .in_valid_i      (pix_i.valid),
    .pixel_byte_i    (pix_i.pixel_byte),
    .frame_start_i   (pix_i.frame_start),
    .out_ready_i     (col_o.ready),
    .column_bytes_o  (col_o.column_bytes),
    .page_index_o    (col_o.page_index),
    .column_group_o  (col_o.column_group),
    .last_of_page_o  (col_o.last_of_page),
    .last_of_frame_o (col_o.last_of_frame)
  );

  // handshake outputs
  assign pix_i.ready = cmd.load_en;
  assign col_o.valid = cmd.out_valid;

endmodule

// ===== hw/rtl/r2c_chk.sv =====
// ----------------------------------------------------------------------------
// r2c_chk
// Port-level checks for the raster to column page converter.
// ----------------------------------------------------------------------------
`include "raster_to_column_page_converter_defines.svh"

module r2c_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] column_bytes_i,
  input logic        last_of_page_i,
  input logic        last_of_frame_i
);

  // loading and emission never overlap
  `R2C_NEVER(a_no_overlap, in_ready_i && out_valid_i, "input ready during emission")

  // a stalled group keeps its data
  `R2C_ASSERT_NEXT(a_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(column_bytes_i), "stalled group changed")

  // loading resumes right after the last group of a page
  `R2C_ASSERT_NEXT(a_resume, out_valid_i && out_ready_i && last_of_page_i, in_ready_i, "no resume after page")

  // frame end only on a page end
  `R2C_ASSERT(a_frame_page, out_valid_i && last_of_frame_i |-> last_of_page_i, "frame end off page end")

endmodule

bind raster_to_column_page_converter r2c_chk u_r2c_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (pix_i.ready),
  .out_valid_i     (col_o.valid),
  .out_ready_i     (col_o.ready),
  .column_bytes_i  (col_o.column_bytes),
  .last_of_page_i  (col_o.last_of_page),
  .last_of_frame_i (col_o.last_of_frame)
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the raster to column page converter. Pixel bytes
// are streamed in with random bursts and gaps while the column side stalls on
// its own pattern. A local page transpose predicts every column group and each
// output transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import r2c_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ImageWidth  = 160;
  localparam int unsigned ImageHeight = 43;
  localparam int unsigned RowBytes    = ImageWidth / 8;
  // a page end costs a read state and an output state per group, plus margin
  localparam int unsigned SettleCycles = 2 * RowBytes + 10;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned ItemTarget   = 420;
  localparam int unsigned ResultTarget = 60;
  localparam int unsigned CycleLimit   = 2000000;

  typedef struct packed {
    logic [63:0] column_bytes;
    logic [2:0]  page_index;
    logic [4:0]  column_group;
    logic        last_of_page;
    logic        last_of_frame;
  } col_group_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic pready;

  r2c_pix_if pix ();
  r2c_col_if col ();

  raster_to_column_page_converter #(
    .IMAGE_WIDTH (ImageWidth),
    .IMAGE_HEIGHT(ImageHeight)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .col_o  (col),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predicted page state
  logic [7:0]  page_rows [8][RowBytes];
  int unsigned frame_row;
  int unsigned row_byte;
  logic        invert_en;

  col_group_t  expected_columns [$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned groups_predicted;
  int unsigned pixels_sent;
  bit          hold_request;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // transpose one eight-column group of the current page
  function automatic logic [63:0] transpose_group(int unsigned grp, int unsigned rows_valid);
    logic [63:0] word;
    word = '0;
    for (int k = 0; k < 8; k++) begin
      for (int j = 0; j < 8; j++) begin
        if (j < rows_valid) word[8*k+j] = page_rows[j][grp][7-k];
      end
    end
    return invert_en ? ~word : word;
  endfunction

  // store one accepted pixel byte and queue the groups it releases
  task automatic predict_pixel(input logic [7:0] pixel, input logic fs);
    int unsigned row_in_page;
    bit frame_end;
    col_group_t grp;
    if (fs) begin
      frame_row = 0;
      row_byte  = 0;
    end
    row_in_page = frame_row % 8;
    page_rows[row_in_page][row_byte] = pixel;
    row_byte++;
    if (row_byte == RowBytes) begin
      row_byte  = 0;
      frame_end = (frame_row == ImageHeight - 1);
      if (row_in_page == 7 || frame_end) begin
        for (int unsigned g = 0; g < RowBytes; g++) begin
          grp.column_bytes  = transpose_group(g, row_in_page + 1);
          grp.page_index    = 3'(frame_row / 8);
          grp.column_group  = 5'(g);
          grp.last_of_page  = (g == RowBytes - 1);
          grp.last_of_frame = (g == RowBytes - 1) && frame_end;
          expected_columns.push_back(grp);
          groups_predicted++;
        end
      end
      frame_row = frame_end ? 0 : frame_row + 1;
    end
  endtask

  // compare each column transaction against the oldest prediction
  always @(posedge clk_i) begin
    col_group_t want;
    if (rst_ni && col.valid && col.ready) begin
      if (expected_columns.size() == 0) begin
        $error("unexpected column group: page %0d group %0d", col.page_index,
               col.column_group);
        error_count++;
      end else begin
        want = expected_columns.pop_front();
        if (col.column_bytes !== want.column_bytes) begin
          $error("column_bytes expected %h actual %h", want.column_bytes, col.column_bytes);
          error_count++;
        end
        if (col.page_index !== want.page_index) begin
          $error("page_index expected %0d actual %0d", want.page_index, col.page_index);
          error_count++;
        end
        if (col.column_group !== want.column_group) begin
          $error("column_group expected %0d actual %0d", want.column_group,
                 col.column_group);
          error_count++;
        end
        if (col.last_of_page !== want.last_of_page) begin
          $error("last_of_page expected %0b actual %0b", want.last_of_page,
                 col.last_of_page);
          error_count++;
        end
        if (col.last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame expected %0b actual %0b", want.last_of_frame,
                 col.last_of_frame);
          error_count++;
        end
      end
    end
  end

  // column side ready: windows of free flow, random stalls and a fixed pattern,
  // plus a long hold-off on request
  initial begin
    int unsigned window;
    int unsigned mode;
    int unsigned phase;
    col.ready = 1'b0;
    window = 0;
    mode   = 0;
    phase  = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        col.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (window == 0) begin
        window = $urandom_range(16, 96);
        mode   = $urandom_range(0, 2);
      end
      window--;
      phase++;
      case (mode)
        0: col.ready <= 1'b1;
        1: col.ready <= ($urandom_range(0, 3) != 0);
        default: col.ready <= (phase % 3 != 0);
      endcase
    end
  end

  // offer one pixel byte and hold it until taken; valid stays high on exit
  task automatic send_pixel(input logic [7:0] pixel, input logic fs);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    pix.valid       <= 1'b1;
    pix.pixel_byte  <= pixel;
    pix.frame_start <= fs;
    do @(posedge clk_i); while (!pix.ready);
    predict_pixel(pixel, fs);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // mostly random content, with the all-clear and all-set bytes mixed in
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_rows(input int unsigned rows, input bit fresh);
    for (int unsigned i = 0; i < rows * RowBytes; i++) begin
      send_pixel(pick_pixel(), fresh && (i == 0));
    end
  endtask

  // stop offering and let every pending group come out
  task automatic wait_drained();
    pix.valid <= 1'b0;
    while (expected_columns.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [CfgDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == CFG_IDX_INVERT) invert_en = value[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // field extremes and frame starts in mid row, no page completes
  task automatic test_directed_bytes();
    logic [7:0] seq [12] = '{8'hff, 8'h00, 8'h80, 8'h01, 8'h7f, 8'hfe,
                             8'h55, 8'haa, 8'h0f, 8'hf0, 8'h3c, 8'hc3};
    for (int i = 0; i < 12; i++) send_pixel(seq[i], i == 0);
    send_pixel(8'h00, 1'b1);
    for (int i = 11; i >= 0; i--) send_pixel(seq[i], 1'b0);
    wait_drained();
  endtask

  // a whole frame with the reset setting, ending on the partial page
  task automatic test_full_frame_inverted();
    send_rows(ImageHeight, 1'b1);
    wait_drained();
  endtask

  // plain output, next frame entered by wrap-around without a frame start
  task automatic test_wrapped_frame_plain();
    cfg_write(CFG_IDX_INVERT, 32'h0000_0000);
    send_rows(ImageHeight, 1'b0);
    wait_drained();
  endtask

  // restarts in mid page and mid row discard the partial page
  task automatic test_mid_page_restart();
    cfg_write(CFG_IDX_INVERT, 32'hffff_ffff);
    send_rows(5, 1'b1);
    send_rows(8, 1'b1);
    send_rows(3, 1'b1);
    for (int i = 0; i < 7; i++) send_pixel(pick_pixel(), 1'b0);
    send_rows(8, 1'b1);
    wait_drained();
  endtask

  // long column stall while pixels keep coming, so the input backs up
  task automatic test_output_hold();
    cfg_write(CFG_IDX_INVERT, 32'hffff_fffe);
    hold_request = 1'b1;
    send_rows(24, 1'b1);
    wait_drained();
  endtask

  // random segments: mostly fresh pages, some unaligned noise
  task automatic test_random_mix();
    int unsigned item_base;
    int unsigned group_base;
    item_base  = pixels_sent;
    group_base = groups_predicted;
    cfg_write(CFG_IDX_INVERT, 32'h0000_0001);
    while (pixels_sent - item_base < ItemTarget ||
           groups_predicted - group_base < ResultTarget) begin
      if ($urandom_range(0, 4) != 0) begin
        send_rows($urandom_range(1, 10), 1'b1);
      end else begin
        repeat ($urandom_range(1, 30)) send_pixel(pick_pixel(), $urandom_range(0, 7) == 0);
      end
      if ($urandom_range(0, 5) == 0) begin
        wait_drained();
        cfg_write(CFG_IDX_INVERT, CfgDataW'($urandom));
      end
    end
    wait_drained();
  endtask

  // main sequence
  initial begin
    rst_ni          = 1'b0;
    pix.valid       = 1'b0;
    pix.pixel_byte  = '0;
    pix.frame_start = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    frame_row        = 0;
    row_byte         = 0;
    invert_en        = 1'b1;
    error_count      = 0;
    cycle_count      = 0;
    burst_left       = 0;
    groups_predicted = 0;
    pixels_sent      = 0;
    hold_request     = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_bytes();
    test_full_frame_inverted();
    test_wrapped_frame_plain();
    test_mid_page_restart();
    test_output_hold();
    test_random_mix();

    if (expected_columns.size() != 0) begin
      $error("%0d column groups never arrived", expected_columns.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
